// ===== design/mewc_pkg.sv =====
// shared types and constants of the meter edge window calibrator
package mewc_pkg;

    // configuration register indexes
    localparam logic REG_CALIB   = 1'b0;
    localparam logic REG_DIVIDER = 1'b1;

    // register reset values
    localparam logic [31:0] CALIB_RESET   = 32'd1000;
    localparam logic [6:0]  DIVIDER_RESET = 7'd6;

    // fixed constants of the tick processing
    localparam int unsigned    DIFF_DEPTH  = 4;
    localparam logic [6:0]     DIV_MAX     = 7'd64;
    localparam logic [13:0]    ML_PER_10L  = 14'd10000;
    localparam logic [31:0]    PAIR_LIMIT  = 32'd100;

    // divider geometry: 32-bit count times a 14-bit scale
    localparam int unsigned DVD_W = 46;
    localparam int unsigned CNT_W = 6;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

    // divider control and status
    typedef struct packed {
        logic start;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // sequencer states
    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_UPDATE = 6'b000010,
        ST_CHECK  = 6'b000100,
        ST_START  = 6'b001000,
        ST_DIV    = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

endpackage

// ===== design/mewc_divider.sv =====
// restoring divider, one quotient bit per cycle, saturating to 32 bits
module mewc_divider (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  mewc_pkg::div_ctl_t           ctl,
    input  logic [mewc_pkg::DVD_W-1:0]   dividend,
    input  logic [31:0]                  divisor,
    output mewc_pkg::div_stat_t          stat,
    output logic [31:0]                  quotient
);

    logic [32:0]                  rem_reg;
    logic [32:0]                  rem_next;
    logic [mewc_pkg::DVD_W-1:0]   quo_reg;
    logic [mewc_pkg::DVD_W-1:0]   quo_next;
    logic [31:0]                  dsr_reg;
    logic [mewc_pkg::CNT_W-1:0]   cnt_reg;
    logic                         busy_reg;
    logic                         done_reg;
    logic [32:0]                  shifted;
    logic                         fits;

    // one restoring step
    always_comb begin
        shifted  = {rem_reg[31:0], quo_reg[mewc_pkg::DVD_W-1]};
        fits     = (shifted >= {1'b0, dsr_reg});
        rem_next = fits ? (shifted - {1'b0, dsr_reg}) : shifted;
        quo_next = {quo_reg[mewc_pkg::DVD_W-2:0], fits};
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= mewc_pkg::CNT_LAST;
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    // saturate quotients beyond 32 bits
    assign quotient  = (|quo_reg[mewc_pkg::DVD_W-1:32]) ? 32'hFFFF_FFFF : quo_reg[31:0];
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== design/meter_edge_window_calibrator.sv =====
// top level of the meter edge window calibrator: tick sequencer, state and output register
//
//  channel  direction  handshake            payload
//  s_       in         s_valid / s_ready    s_flow_pulse, s_meter_level
//  m_       out        m_valid / m_ready    volume, edge total, line, edge, calibration
//  cfg_     in         cfg_wr_en            cfg_index, cfg_wdata
//
// a tick passes the update, check and start states, then the divide state waits on
// the bit-serial divider (46 quotient steps) that turns pulse_count * 10000 into
// millilitres, and the done state hands the result to the output register.
// a zero divisor skips the divider and gives a volume of zero.
// s_ready is high only while the sequencer is idle; a result waiting in the
// output register does not block the next tick until that tick is finished.
// synchronous active-low reset clears control and tick state, no clearing pass is needed.
module meter_edge_window_calibrator #(
    parameter int unsigned WINDOW_LEN = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata,
    // tick input
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_flow_pulse,
    input  logic        s_meter_level,
    // result output
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_volume_ml,
    output logic [31:0] m_edge_total,
    output logic        m_line_high,
    output logic        m_edge_now,
    output logic        m_cal_valid,
    output logic [31:0] m_cal_value
);

    localparam logic [WINDOW_LEN-1:0] WIN_FULL = {WINDOW_LEN{1'b1}};

    mewc_pkg::state_t state_reg;

    // configuration registers
    logic [31:0] calib_reg;
    logic [6:0]  divider_reg;

    // tick state
    logic [31:0]           pulse_count_reg;
    logic [5:0]            prescale_reg;
    logic [WINDOW_LEN-1:0] window_reg;
    logic                  line_state_reg;
    logic                  awaiting_first_reg;
    logic [31:0]           edge_counter_reg;
    logic [31:0]           cap_low_reg;
    logic [31:0]           cap_high_reg;
    logic [31:0]           diff_store_reg [mewc_pkg::DIFF_DEPTH];
    logic [1:0]            diff_index_reg;

    // per-tick working registers
    logic                       pulse_in_reg;
    logic                       level_in_reg;
    logic                       edge_now_reg;
    logic                       check_reg;
    logic                       cal_valid_reg;
    logic [31:0]                cal_value_reg;
    logic [mewc_pkg::DVD_W-1:0] product_reg;
    logic [31:0]                volume_reg;

    // output register
    logic        m_valid_reg;
    logic [31:0] m_volume_reg;
    logic [31:0] m_edge_total_reg;
    logic        m_line_high_reg;
    logic        m_edge_now_reg;
    logic        m_cal_valid_reg;
    logic [31:0] m_cal_value_reg;

    // tick update logic
    logic [31:0]           pulse_next;
    logic [6:0]            eff_div;
    logic [6:0]            pre_inc;
    logic                  sample;
    logic [WINDOW_LEN-1:0] window_next;
    logic                  to_low;
    logic                  to_high;
    logic                  edge_next;
    logic [31:0]           cap_low_next;
    logic [31:0]           cap_high_next;
    logic                  store_diff;
    logic [31:0]           diff_val;
    logic [1:0]            diff_index_next;

    // calibration check logic
    logic [31:0] d02;
    logic [31:0] d13;
    logic [31:0] sum4;

    // divider
    mewc_pkg::div_ctl_t  div_ctl;
    mewc_pkg::div_stat_t div_stat;
    logic [31:0]         div_quot;

    logic out_free;

    assign s_ready  = (state_reg == mewc_pkg::ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    // next tick state from the latched transaction
    always_comb begin
        pulse_next = pulse_count_reg + {31'd0, pulse_in_reg};
        eff_div    = divider_reg;
        if (eff_div == 7'd0) begin
            eff_div = 7'd1;
        end else if (eff_div > mewc_pkg::DIV_MAX) begin
            eff_div = mewc_pkg::DIV_MAX;
        end
        pre_inc     = {1'b0, prescale_reg} + 7'd1;
        sample      = !(pre_inc < eff_div);
        window_next = {window_reg[WINDOW_LEN-2:0], level_in_reg};
        to_low      = sample && (window_next == '0) &&
                      (awaiting_first_reg || line_state_reg);
        to_high     = sample && !to_low && (window_next == WIN_FULL) &&
                      (awaiting_first_reg || !line_state_reg);
        edge_next     = (to_low || to_high) && !awaiting_first_reg;
        cap_low_next  = (edge_next && to_low) ? pulse_next : cap_low_reg;
        cap_high_next = (edge_next && to_high) ? pulse_next : cap_high_reg;
        store_diff    = edge_next && (cap_low_next != '0) && (cap_high_next != '0);
        diff_val      = (cap_low_next > cap_high_next) ? (cap_low_next - cap_high_next)
                                                       : (cap_high_next - cap_low_next);
        diff_index_next = diff_index_reg + 2'd1;
    end

    // pair agreement and estimate over the filled store
    always_comb begin
        d02  = (diff_store_reg[0] > diff_store_reg[2])
               ? (diff_store_reg[0] - diff_store_reg[2])
               : (diff_store_reg[2] - diff_store_reg[0]);
        d13  = (diff_store_reg[1] > diff_store_reg[3])
               ? (diff_store_reg[1] - diff_store_reg[3])
               : (diff_store_reg[3] - diff_store_reg[1]);
        sum4 = diff_store_reg[0] + diff_store_reg[1] + diff_store_reg[2] + diff_store_reg[3];
    end

    assign div_ctl.start = (state_reg == mewc_pkg::ST_START) && (calib_reg != '0);

    mewc_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (div_ctl),
        .dividend (product_reg),
        .divisor  (calib_reg),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            calib_reg   <= mewc_pkg::CALIB_RESET;
            divider_reg <= mewc_pkg::DIVIDER_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                mewc_pkg::REG_CALIB:   calib_reg   <= cfg_wdata;
                mewc_pkg::REG_DIVIDER: divider_reg <= cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    // sequencer and tick state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= mewc_pkg::ST_IDLE;
            pulse_count_reg    <= '0;
            prescale_reg       <= '0;
            window_reg         <= '0;
            line_state_reg     <= 1'b0;
            awaiting_first_reg <= 1'b1;
            edge_counter_reg   <= '0;
            cap_low_reg        <= '0;
            cap_high_reg       <= '0;
            for (int i = 0; i < mewc_pkg::DIFF_DEPTH; i++) begin
                diff_store_reg[i] <= '0;
            end
            diff_index_reg     <= '0;
            edge_now_reg       <= 1'b0;
            check_reg          <= 1'b0;
            cal_valid_reg      <= 1'b0;
        end else begin
            case (state_reg)
                mewc_pkg::ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= mewc_pkg::ST_UPDATE;
                    end
                end
                mewc_pkg::ST_UPDATE: begin
                    pulse_count_reg <= pulse_next;
                    prescale_reg    <= sample ? 6'd0 : pre_inc[5:0];
                    if (sample) begin
                        window_reg <= window_next;
                    end
                    if (to_low || to_high) begin
                        line_state_reg     <= to_high;
                        awaiting_first_reg <= 1'b0;
                    end
                    if (edge_next) begin
                        edge_counter_reg <= edge_counter_reg + 32'd1;
                    end
                    cap_low_reg  <= cap_low_next;
                    cap_high_reg <= cap_high_next;
                    if (store_diff) begin
                        diff_store_reg[diff_index_reg] <= diff_val;
                        diff_index_reg                 <= diff_index_next;
                    end
                    edge_now_reg <= edge_next;
                    check_reg    <= store_diff && (diff_index_next == 2'd0);
                    state_reg    <= mewc_pkg::ST_CHECK;
                end
                mewc_pkg::ST_CHECK: begin
                    cal_valid_reg <= check_reg && (d02 < mewc_pkg::PAIR_LIMIT) &&
                                     (d13 < mewc_pkg::PAIR_LIMIT);
                    state_reg     <= mewc_pkg::ST_START;
                end
                mewc_pkg::ST_START: begin
                    state_reg <= (calib_reg == '0) ? mewc_pkg::ST_DONE : mewc_pkg::ST_DIV;
                end
                mewc_pkg::ST_DIV: begin
                    if (div_stat.done) begin
                        state_reg <= mewc_pkg::ST_DONE;
                    end
                end
                mewc_pkg::ST_DONE: begin
                    if (out_free) begin
                        state_reg <= mewc_pkg::ST_IDLE;
                    end
                end
                default: state_reg <= mewc_pkg::ST_IDLE;
            endcase
        end
    end

    // working payload registers
    always_ff @(posedge aclk) begin
        if (state_reg == mewc_pkg::ST_IDLE && s_valid) begin
            pulse_in_reg <= s_flow_pulse;
            level_in_reg <= s_meter_level;
        end
        if (state_reg == mewc_pkg::ST_CHECK) begin
            product_reg   <= {14'd0, pulse_count_reg} * {32'd0, mewc_pkg::ML_PER_10L};
            cal_value_reg <= {1'b0, sum4[31:1]};
        end
        if (state_reg == mewc_pkg::ST_START) begin
            volume_reg <= '0;
        end else if (state_reg == mewc_pkg::ST_DIV && div_stat.done) begin
            volume_reg <= div_quot;
        end
    end

    // output register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == mewc_pkg::ST_DONE && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge aclk) begin
        if (state_reg == mewc_pkg::ST_DONE && out_free) begin
            m_volume_reg     <= volume_reg;
            m_edge_total_reg <= edge_counter_reg;
            m_line_high_reg  <= line_state_reg;
            m_edge_now_reg   <= edge_now_reg;
            m_cal_valid_reg  <= cal_valid_reg;
            m_cal_value_reg  <= cal_valid_reg ? cal_value_reg : 32'd0;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_volume_ml  = m_volume_reg;
    assign m_edge_total = m_edge_total_reg;
    assign m_line_high  = m_line_high_reg;
    assign m_edge_now   = m_edge_now_reg;
    assign m_cal_valid  = m_cal_valid_reg;
    assign m_cal_value  = m_cal_value_reg;

endmodule

// ===== tb/sv/meter_edge_window_calibrator_tb.sv =====
// self-checking testbench of the meter edge window calibrator
module meter_edge_window_calibrator_tb;

    localparam int unsigned WINDOW_LEN  = 10;
    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    localparam int unsigned DRAIN_WAIT  = 60;

    // one expected tick result
    typedef struct packed {
        logic [31:0] volume_ml;
        logic [31:0] edge_total;
        logic        line_high;
        logic        edge_now;
        logic        cal_valid;
        logic [31:0] cal_value;
    } meter_reading_t;

    typedef enum logic {
        ROW_TICK,
        ROW_CFG
    } row_kind_t;

    // one row of the directed stimulus
    typedef struct packed {
        row_kind_t      kind;
        logic           flow;
        logic           level;
        logic           cfg_index;
        logic [31:0]    cfg_data;
        logic           typed;
        meter_reading_t want;
    } directed_row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [31:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic        s_flow_pulse;
    logic        s_meter_level;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_volume_ml;
    logic [31:0] m_edge_total;
    logic        m_line_high;
    logic        m_edge_now;
    logic        m_cal_valid;
    logic [31:0] m_cal_value;

    // predicted block state and configuration
    logic [31:0]          pm_calib     = mewc_pkg::CALIB_RESET;
    logic [6:0]           pm_divider   = mewc_pkg::DIVIDER_RESET;
    logic [31:0]          pm_pulses    = '0;
    logic [5:0]           pm_prescale  = '0;
    logic [WINDOW_LEN-1:0] pm_window   = '0;
    logic                 pm_line      = 1'b0;
    logic                 pm_awaiting  = 1'b1;
    logic [31:0]          pm_edges     = '0;
    logic [31:0]          pm_cap_low   = '0;
    logic [31:0]          pm_cap_high  = '0;
    logic [mewc_pkg::DIFF_DEPTH-1:0][31:0] pm_diffs = '0;
    logic [1:0]           pm_diff_idx  = '0;

    meter_reading_t pending_readings [$];
    directed_row_t  directed_table [$];
    int unsigned    mismatch_count = 0;
    int unsigned    cycle_count    = 0;
    int unsigned    sent_count     = 0;
    logic           gapless        = 1'b0;
    int unsigned    rx_hold        = 0;

    meter_edge_window_calibrator #(
        .WINDOW_LEN(WINDOW_LEN)
    ) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_flow_pulse (s_flow_pulse),
        .s_meter_level(s_meter_level),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_volume_ml  (m_volume_ml),
        .m_edge_total (m_edge_total),
        .m_line_high  (m_line_high),
        .m_edge_now   (m_edge_now),
        .m_cal_valid  (m_cal_valid),
        .m_cal_value  (m_cal_value)
    );

    // clock
    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("meter_edge_window_calibrator_tb: FAIL");
            $finish;
        end
    end

    task automatic report_error(input string msg);
        begin
            $display("[%0d] mismatch: %s", cycle_count, msg);
            mismatch_count++;
        end
    endtask

    function automatic logic [31:0] gap_of(input logic [31:0] a, input logic [31:0] b);
        gap_of = (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic int unsigned effective_divider();
        if (pm_divider == 7'd0)
            effective_divider = 1;
        else if (pm_divider > mewc_pkg::DIV_MAX)
            effective_divider = mewc_pkg::DIV_MAX;
        else
            effective_divider = pm_divider;
    endfunction

    // next reading of the meter for one tick, advances the predicted state
    task automatic advance_meter(input logic flow, input logic level,
                                 output meter_reading_t rd);
        logic        flipped;
        logic [31:0] sum;
        logic [63:0] vol;
        begin
            rd      = '0;
            flipped = 1'b0;
            if (flow)
                pm_pulses = pm_pulses + 32'd1;

            if (pm_prescale + 1 < effective_divider()) begin
                pm_prescale = pm_prescale + 6'd1;
            end else begin
                pm_prescale = '0;
                pm_window   = {pm_window[WINDOW_LEN-2:0], level};
                // qualified flips, the first settle counts no edge
                if (pm_window == '0 && (pm_awaiting || pm_line)) begin
                    pm_line = 1'b0;
                    if (!pm_awaiting) begin
                        flipped    = 1'b1;
                        pm_cap_low = pm_pulses;
                    end
                    pm_awaiting = 1'b0;
                end else if (pm_window == '1 && (pm_awaiting || !pm_line)) begin
                    pm_line = 1'b1;
                    if (!pm_awaiting) begin
                        flipped     = 1'b1;
                        pm_cap_high = pm_pulses;
                    end
                    pm_awaiting = 1'b0;
                end
                // difference store and pairwise agreement
                if (flipped) begin
                    pm_edges = pm_edges + 32'd1;
                    if (pm_cap_low != 0 && pm_cap_high != 0) begin
                        pm_diffs[pm_diff_idx] = gap_of(pm_cap_low, pm_cap_high);
                        pm_diff_idx = pm_diff_idx + 2'd1;
                        if (pm_diff_idx == 2'd0 &&
                            gap_of(pm_diffs[0], pm_diffs[2]) < mewc_pkg::PAIR_LIMIT &&
                            gap_of(pm_diffs[1], pm_diffs[3]) < mewc_pkg::PAIR_LIMIT) begin
                            sum = pm_diffs[0] + pm_diffs[1] + pm_diffs[2] + pm_diffs[3];
                            rd.cal_valid = 1'b1;
                            rd.cal_value = sum >> 1;
                        end
                    end
                end
            end

            // volume with saturation, zero for a zero divisor
            if (pm_calib == 0) begin
                vol = '0;
            end else begin
                vol = ({32'd0, pm_pulses} * 64'(mewc_pkg::ML_PER_10L)) / {32'd0, pm_calib};
                if (vol > 64'hFFFF_FFFF)
                    vol = 64'hFFFF_FFFF;
            end
            rd.volume_ml  = vol[31:0];
            rd.edge_total = pm_edges;
            rd.line_high  = pm_line;
            rd.edge_now   = flipped;
        end
    endtask

    // sender: lower valid and wait until every result is back
    task automatic wait_for_drain();
        begin
            s_valid = 1'b0;
            while (pending_readings.size() != 0)
                @(negedge aclk);
        end
    endtask

    task automatic write_register(input logic idx, input logic [31:0] data);
        begin
            wait_for_drain();
            cfg_wr_en = 1'b1;
            cfg_index = idx;
            cfg_wdata = data;
            @(negedge aclk);
            cfg_wr_en = 1'b0;
            if (idx == mewc_pkg::REG_CALIB)
                pm_calib = data;
            else
                pm_divider = data[6:0];
        end
    endtask

    // one tick transaction with an optional random gap in front
    task automatic send_tick(input logic flow, input logic level,
                             input logic typed, input meter_reading_t typed_rd);
        int unsigned    gap;
        int unsigned    roll;
        meter_reading_t rd;
        begin
            if (sent_count % 64 == 0)
                gapless = ($urandom_range(0, 3) == 0);
            sent_count++;
            gap = 0;
            if (!gapless) begin
                roll = $urandom_range(0, 99);
                if (roll >= 92)
                    gap = $urandom_range(10, 120);
                else if (roll >= 55)
                    gap = $urandom_range(1, 3);
            end
            if (gap != 0) begin
                s_valid       = 1'b0;
                s_flow_pulse  = 1'($urandom_range(0, 1));
                s_meter_level = 1'($urandom_range(0, 1));
                repeat (gap) @(negedge aclk);
            end
            s_valid       = 1'b1;
            s_flow_pulse  = flow;
            s_meter_level = level;
            @(posedge aclk);
            while (!s_ready)
                @(posedge aclk);
            advance_meter(flow, level, rd);
            pending_readings.push_back(typed ? typed_rd : rd);
            @(negedge aclk);
        end
    endtask

    // random ticks shaped as level runs of the reference meter
    task automatic run_phase(input int unsigned n_items);
        int unsigned done_items;
        int unsigned ticks;
        int unsigned density;
        int unsigned roll;
        int unsigned eff;
        int unsigned k;
        logic        run_level;
        logic        lvl;
        logic        noisy;
        begin
            done_items = 0;
            density    = $urandom_range(20, 100);
            run_level  = pm_line;
            while (done_items < n_items) begin
                eff   = effective_divider();
                roll  = $urandom_range(0, 99);
                noisy = 1'b0;
                lvl   = run_level;
                if (roll < 8) begin
                    // noise
                    noisy = 1'b1;
                    ticks = $urandom_range(1, 8);
                end else if (roll < 16) begin
                    // broken run, too short to qualify
                    lvl   = ~run_level;
                    ticks = $urandom_range(2, 8) * eff;
                end else begin
                    run_level = ~run_level;
                    lvl       = run_level;
                    if (eff == 1 && roll >= 92)
                        ticks = $urandom_range(120, 220);
                    else if (roll >= 80)
                        ticks = $urandom_range(14, 40) * eff;
                    else
                        ticks = $urandom_range(10, 13) * eff;
                end
                if (ticks > n_items - done_items)
                    ticks = n_items - done_items;
                for (k = 0; k < ticks; k++) begin
                    send_tick(1'($urandom_range(0, 99) < density),
                              noisy ? 1'($urandom_range(0, 1)) : lvl, 1'b0, '0);
                    if ($urandom_range(0, 299) == 0)
                        wait_for_drain();
                end
                done_items += ticks;
            end
        end
    endtask

    function automatic directed_row_t tick_row(input logic flow, input logic level);
        tick_row       = '0;
        tick_row.kind  = ROW_TICK;
        tick_row.flow  = flow;
        tick_row.level = level;
    endfunction

    function automatic directed_row_t typed_row(input logic flow, input logic level,
                                                input logic [31:0] volume,
                                                input logic [31:0] edges,
                                                input logic line);
        typed_row                 = tick_row(flow, level);
        typed_row.typed           = 1'b1;
        typed_row.want.volume_ml  = volume;
        typed_row.want.edge_total = edges;
        typed_row.want.line_high  = line;
    endfunction

    function automatic directed_row_t cfg_row(input logic idx, input logic [31:0] data);
        cfg_row           = '0;
        cfg_row.kind      = ROW_CFG;
        cfg_row.cfg_index = idx;
        cfg_row.cfg_data  = data;
    endfunction

    // result checker
    always @(posedge aclk) begin : result_check
        meter_reading_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_readings.size() == 0) begin
                report_error("result transaction with nothing expected");
            end else begin
                want = pending_readings.pop_front();
                if (m_volume_ml !== want.volume_ml)
                    report_error($sformatf("volume_ml got %0d want %0d",
                                           m_volume_ml, want.volume_ml));
                if (m_edge_total !== want.edge_total)
                    report_error($sformatf("edge_total got %0d want %0d",
                                           m_edge_total, want.edge_total));
                if (m_line_high !== want.line_high)
                    report_error($sformatf("line_high got %b want %b",
                                           m_line_high, want.line_high));
                if (m_edge_now !== want.edge_now)
                    report_error($sformatf("edge_now got %b want %b",
                                           m_edge_now, want.edge_now));
                if (m_cal_valid !== want.cal_valid)
                    report_error($sformatf("cal_valid got %b want %b",
                                           m_cal_valid, want.cal_valid));
                if (m_cal_value !== want.cal_value)
                    report_error($sformatf("cal_value got %0d want %0d",
                                           m_cal_value, want.cal_value));
            end
        end
    end

    // receiver: random stalls, calm stretches and two long hold-offs
    initial begin : result_sink
        int unsigned roll;
        m_ready = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (cycle_count == 15000 || cycle_count == 60000)
                rx_hold = 800;
            if (rx_hold != 0) begin
                m_ready = 1'b0;
                rx_hold--;
            end else if ((cycle_count / 4096) % 4 == 1) begin
                m_ready = 1'b1;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 75) begin
                    m_ready = 1'b1;
                end else begin
                    m_ready = 1'b0;
                    rx_hold = (roll < 97) ? $urandom_range(0, 3) : $urandom_range(20, 150);
                end
            end
        end
    end

    // stimulus
    initial begin : tick_source
        int unsigned phase;
        int unsigned n_items;
        logic [31:0] calib_val;
        logic [31:0] div_val;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_flow_pulse  = 1'b0;
        s_meter_level = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = mewc_pkg::REG_CALIB;
        cfg_wdata     = '0;

        // reset values first, then divisor extremes, divider zero and saturation
        directed_table = '{
            typed_row(1'b1, 1'b1, 32'd10, 32'd0, 1'b0),
            typed_row(1'b1, 1'b0, 32'd20, 32'd0, 1'b0),
            typed_row(1'b0, 1'b0, 32'd20, 32'd0, 1'b0),
            cfg_row(mewc_pkg::REG_CALIB, 32'd0),
            typed_row(1'b1, 1'b1, 32'd0, 32'd0, 1'b0),
            cfg_row(mewc_pkg::REG_CALIB, 32'd1),
            typed_row(1'b0, 1'b1, 32'd30000, 32'd0, 1'b0),
            cfg_row(mewc_pkg::REG_CALIB, 32'hFFFF_FFFF),
            typed_row(1'b1, 1'b1, 32'd0, 32'd0, 1'b0),
            cfg_row(mewc_pkg::REG_CALIB, 32'd3),
            tick_row(1'b1, 1'b0),
            cfg_row(mewc_pkg::REG_DIVIDER, 32'd0),
            tick_row(1'b1, 1'b1), tick_row(1'b0, 1'b1), tick_row(1'b1, 1'b1),
            tick_row(1'b1, 1'b1), tick_row(1'b0, 1'b1), tick_row(1'b0, 1'b1),
            tick_row(1'b1, 1'b1), tick_row(1'b1, 1'b1), tick_row(1'b0, 1'b1),
            tick_row(1'b1, 1'b1),
            cfg_row(mewc_pkg::REG_DIVIDER, 32'hA5A5_A5FF),
            tick_row(1'b0, 1'b0),
            tick_row(1'b1, 1'b1),
            cfg_row(mewc_pkg::REG_DIVIDER, 32'd64),
            tick_row(1'b1, 1'b0)
        };

        repeat (7) @(negedge aclk);
        aresetn = 1'b1;

        // directed part
        foreach (directed_table[i]) begin
            if (directed_table[i].kind == ROW_CFG)
                write_register(directed_table[i].cfg_index, directed_table[i].cfg_data);
            else
                send_tick(directed_table[i].flow, directed_table[i].level,
                          directed_table[i].typed, directed_table[i].want);
        end

        // random phases over several register settings
        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    calib_val = 32'd1000;       div_val = 32'd1;   n_items = 280;
                end
                1: begin
                    calib_val = 32'd0;          div_val = 32'd2;   n_items = 260;
                end
                2: begin
                    calib_val = 32'hFFFF_FFFF;  div_val = 32'd0;   n_items = 260;
                end
                3: begin
                    calib_val = 32'd1;          div_val = 32'd1;   n_items = 280;
                end
                4: begin
                    calib_val = $urandom();     div_val = 32'd3;   n_items = 250;
                end
                5: begin
                    calib_val = $urandom_range(1, 5000);
                    div_val   = 32'd64;
                    n_items   = 100;
                end
                6: begin
                    calib_val = $urandom();
                    div_val   = ($urandom() & ~32'h7F) | 32'd100;
                    n_items   = 100;
                end
                default: begin
                    calib_val = $urandom_range(500, 2000);
                    div_val   = 32'd1;
                    n_items   = 320;
                end
            endcase
            write_register(mewc_pkg::REG_CALIB, calib_val);
            write_register(mewc_pkg::REG_DIVIDER, div_val);
            run_phase(n_items);
        end

        // end of run
        wait_for_drain();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (pending_readings.size() != 0)
            report_error($sformatf("%0d results never arrived", pending_readings.size()));
        if (mismatch_count == 0)
            $display("meter_edge_window_calibrator_tb: PASS");
        else
            $display("meter_edge_window_calibrator_tb: FAIL");
        $finish;
    end

endmodule
